// ----- design/hcp_pkg.sv -----
// Shared types, codes and sizes of the handler cycle profiler.
package hcp_pkg;

  localparam int NUM_HANDLER_SLOTS = 64;
  localparam int NUM_INSTR_KINDS   = 256;

  localparam int SLOT_AW = (NUM_HANDLER_SLOTS > 1) ? $clog2(NUM_HANDLER_SLOTS) : 1;
  localparam int KIND_AW = (NUM_INSTR_KINDS > 1) ? $clog2(NUM_INSTR_KINDS) : 1;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  localparam logic [2:0] OP_ENTER     = 3'd0;
  localparam logic [2:0] OP_EXIT      = 3'd1;
  localparam logic [2:0] OP_COUNT     = 3'd2;
  localparam logic [2:0] OP_READ_SLOT = 3'd3;
  localparam logic [2:0] OP_READ_KIND = 3'd4;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_NO_OPEN = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CALC,
    S_UPDATE,
    S_RESPOND
  } state_t;

  typedef struct packed {
    logic capture;
    logic read;
    logic calc;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic [63:0] stamp;
    logic [63:0] total;
    logic [31:0] calls;
    logic [63:0] longest;
  } slot_row_t;

endpackage

// ----- design/hcp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/hcp_ctrl.sv -----
// Controller state machine that sequences one word through the datapath.
module hcp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output hcp_pkg::cmd_t cmd
);
  import hcp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (start) state_next = S_READ;
      S_READ:    state_next = S_CALC;
      S_CALC:    state_next = S_UPDATE;
      S_UPDATE:  state_next = S_RESPOND;
      S_RESPOND: state_next = start ? S_READ : S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b1;
    done        = 1'b0;
    cmd.read    = 1'b0;
    cmd.calc    = 1'b0;
    cmd.update  = 1'b0;
    case (state)
      S_IDLE:    busy = 1'b0;
      S_READ:    cmd.read = 1'b1;
      S_CALC:    cmd.calc = 1'b1;
      S_UPDATE:  cmd.update = 1'b1;
      S_RESPOND: begin
        busy = 1'b0;
        done = 1'b1;
      end
      default:   busy = 1'b0;
    endcase
    cmd.capture = start && !busy;
  end

endmodule

// ----- design/hcp_datapath.sv -----
// Datapath: slot and kind tables, read-modify-write arithmetic and result registers.
module hcp_datapath (
  input  logic          clk,
  input  logic          rst,
  input  hcp_pkg::cmd_t cmd,
  input  logic [2:0]    operation,
  input  logic [7:0]    index,
  input  logic [63:0]   cycle,
  output logic [1:0]    status,
  output logic [31:0]   calls_done,
  output logic [63:0]   cycles_sum,
  output logic [63:0]   cycles_peak,
  output logic          entry_open,
  output logic [31:0]   instr_count
);
  import hcp_pkg::*;

  localparam int SLOT_VW = 1 << SLOT_AW;
  localparam int KIND_VW = 1 << KIND_AW;

  logic [2:0]  op;
  logic [7:0]  idx;
  logic [63:0] cyc;

  logic [SLOT_VW-1:0] slot_valid;
  logic [KIND_VW-1:0] kind_valid;

  logic [SLOT_AW-1:0] slot_addr;
  logic [KIND_AW-1:0] kind_addr;
  logic               slot_ok;
  logic               kind_ok;
  logic               is_slot_op;
  logic               is_kind_op;

  slot_row_t   slot_rdata;
  logic [31:0] kind_rdata;
  slot_row_t   row;
  logic [31:0] kind_val;
  logic [63:0] elapsed;

  slot_row_t   row_new;
  logic        slot_wr;
  logic [31:0] kind_new;
  logic        kind_wr;
  logic        exit_ok;
  logic [63:0] total_sum;
  logic [63:0] longest_new;
  logic [31:0] calls_new;

  assign slot_addr  = idx[SLOT_AW-1:0];
  assign kind_addr  = idx[KIND_AW-1:0];
  assign slot_ok    = {1'b0, idx} < 9'(NUM_HANDLER_SLOTS);
  assign kind_ok    = {1'b0, idx} < 9'(NUM_INSTR_KINDS);
  assign is_slot_op = (op == OP_ENTER) || (op == OP_EXIT) || (op == OP_READ_SLOT);
  assign is_kind_op = (op == OP_COUNT) || (op == OP_READ_KIND);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op  <= operation;
      idx <= index;
      cyc <= cycle;
    end
  end

  hcp_ram #(
    .WIDTH ($bits(slot_row_t)),
    .DEPTH (NUM_HANDLER_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (slot_wr),
    .wr_addr (slot_addr),
    .wr_data (row_new),
    .rd_en   (cmd.read),
    .rd_addr (slot_addr),
    .rd_data (slot_rdata)
  );

  hcp_ram #(
    .WIDTH (32),
    .DEPTH (NUM_INSTR_KINDS)
  ) u_kind_ram (
    .clk     (clk),
    .wr_en   (kind_wr),
    .wr_addr (kind_addr),
    .wr_data (kind_new),
    .rd_en   (cmd.read),
    .rd_addr (kind_addr),
    .rd_data (kind_rdata)
  );

  // An entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      row      <= slot_valid[slot_addr] ? slot_rdata : '0;
      kind_val <= kind_valid[kind_addr] ? kind_rdata : '0;
      elapsed  <= cyc - (slot_valid[slot_addr] ? slot_rdata.stamp : 64'd0);
    end
  end

  always_comb begin
    exit_ok     = row.stamp != 64'd0;
    total_sum   = row.total + elapsed;
    longest_new = (elapsed > row.longest) ? elapsed : row.longest;
    calls_new   = (row.calls == CNT_MAX) ? row.calls : row.calls + 32'd1;
    kind_new    = (kind_val == CNT_MAX) ? kind_val : kind_val + 32'd1;

    row_new = row;
    slot_wr = 1'b0;
    if (op == OP_ENTER) begin
      row_new.stamp = cyc;
      slot_wr       = cmd.update && slot_ok;
    end else if ((op == OP_EXIT) && exit_ok) begin
      row_new.stamp   = 64'd0;
      row_new.total   = total_sum;
      row_new.calls   = calls_new;
      row_new.longest = longest_new;
      slot_wr         = cmd.update && slot_ok;
    end
    kind_wr = cmd.update && kind_ok && (op == OP_COUNT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      kind_valid <= '0;
    end else begin
      if (slot_wr) begin
        slot_valid[slot_addr] <= 1'b1;
      end
      if (kind_wr) begin
        kind_valid[kind_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (is_slot_op && slot_ok) begin
        status      <= ((op == OP_EXIT) && !exit_ok) ? ST_NO_OPEN : ST_DONE;
        calls_done  <= row_new.calls;
        cycles_sum  <= row_new.total;
        cycles_peak <= row_new.longest;
        entry_open  <= row_new.stamp != 64'd0;
        instr_count <= 32'd0;
      end else if (is_kind_op && kind_ok) begin
        status      <= ST_DONE;
        calls_done  <= 32'd0;
        cycles_sum  <= 64'd0;
        cycles_peak <= 64'd0;
        entry_open  <= 1'b0;
        instr_count <= (op == OP_COUNT) ? kind_new : kind_val;
      end else begin
        status      <= ST_IGNORED;
        calls_done  <= 32'd0;
        cycles_sum  <= 64'd0;
        cycles_peak <= 64'd0;
        entry_open  <= 1'b0;
        instr_count <= 32'd0;
      end
    end
  end

endmodule

// ----- design/handler_cycle_profiler.sv -----
// Top level of the handler cycle profiler: controller plus datapath.
// A word is accepted when start is high and busy is low; its result appears
// with done high for one cycle, after the read, calc and update states.
// No new word is taken before the last reaches the respond state, as set by
// the read, compute and write-back sequence on the tables' registered read.
// Synchronous reset returns the controller to idle and clears all table valid
// bits, so every counter reads as zero at once; the receiver cannot stall.
module handler_cycle_profiler (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation,
  input  logic [7:0]  index,
  input  logic [63:0] cycle,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] calls_done,
  output logic [63:0] cycles_sum,
  output logic [63:0] cycles_peak,
  output logic        entry_open,
  output logic [31:0] instr_count
);
  import hcp_pkg::*;

  cmd_t cmd;

  hcp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  hcp_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .operation   (operation),
    .index       (index),
    .cycle       (cycle),
    .status      (status),
    .calls_done  (calls_done),
    .cycles_sum  (cycles_sum),
    .cycles_peak (cycles_peak),
    .entry_open  (entry_open),
    .instr_count (instr_count)
  );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the handler cycle profiler with a predicting scoreboard.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hcp_pkg::*;

  localparam logic [2:0] OP_TOP     = 3'd7;
  localparam int         IDLE_LIMIT = 2000;
  localparam int         NUM_RANDOM = 700;
  localparam int         DRAIN_WAIT = 12;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] calls;
    logic [63:0] total;
    logic [63:0] longest;
    logic        is_open;
    logic [31:0] instr;
  } profile_result_t;

  class profile_scoreboard;
    logic [63:0]     stamp[NUM_HANDLER_SLOTS];
    logic [63:0]     total[NUM_HANDLER_SLOTS];
    logic [31:0]     calls[NUM_HANDLER_SLOTS];
    logic [63:0]     longest[NUM_HANDLER_SLOTS];
    logic [31:0]     kind_hits[NUM_INSTR_KINDS];
    profile_result_t pending[$];
    int              mismatches;
    int              checked;

    function new();
      foreach (stamp[i]) begin
        stamp[i]   = '0;
        total[i]   = '0;
        calls[i]   = '0;
        longest[i] = '0;
      end
      foreach (kind_hits[i]) kind_hits[i] = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void note_word(input logic [2:0] op, input logic [7:0] idx,
                            input logic [63:0] cyc);
      profile_result_t r;
      logic [63:0]     elapsed;
      r = '0;
      if (op == OP_ENTER || op == OP_EXIT || op == OP_READ_SLOT) begin
        if (idx >= NUM_HANDLER_SLOTS) begin
          r.status = ST_IGNORED;
        end else begin
          r.status = ST_DONE;
          if (op == OP_ENTER) begin
            stamp[idx] = cyc;
          end else if (op == OP_EXIT) begin
            if (stamp[idx] == '0) begin
              r.status = ST_NO_OPEN;
            end else begin
              elapsed    = cyc - stamp[idx];
              total[idx] = total[idx] + elapsed;
              if (calls[idx] != CNT_MAX) calls[idx] = calls[idx] + 1;
              if (elapsed > longest[idx]) longest[idx] = elapsed;
              stamp[idx] = '0;
            end
          end
          r.calls   = calls[idx];
          r.total   = total[idx];
          r.longest = longest[idx];
          r.is_open = (stamp[idx] != '0);
        end
      end else if (op == OP_COUNT || op == OP_READ_KIND) begin
        if (idx >= NUM_INSTR_KINDS) begin
          r.status = ST_IGNORED;
        end else begin
          if (op == OP_COUNT && kind_hits[idx] != CNT_MAX)
            kind_hits[idx] = kind_hits[idx] + 1;
          r.status = ST_DONE;
          r.instr  = kind_hits[idx];
        end
      end else begin
        r.status = ST_IGNORED;
      end
      pending.push_back(r);
    endfunction

    function void check_result(input profile_result_t got);
      profile_result_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result word with nothing expected: %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.calls !== want.calls ||
          got.total !== want.total || got.longest !== want.longest ||
          got.is_open !== want.is_open || got.instr !== want.instr) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result word %0d differs", checked);
          $display("  expected status=%0d calls=%h total=%h max=%h open=%b instr=%h",
                   want.status, want.calls, want.total, want.longest, want.is_open,
                   want.instr);
          $display("  actual   status=%0d calls=%h total=%h max=%h open=%b instr=%h",
                   got.status, got.calls, got.total, got.longest, got.is_open,
                   got.instr);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  operation;
  logic [7:0]  index;
  logic [63:0] cycle;
  logic        done;
  logic [1:0]  status;
  logic [31:0] calls_done;
  logic [63:0] cycles_sum;
  logic [63:0] cycles_peak;
  logic        entry_open;
  logic [31:0] instr_count;

  profile_scoreboard sb;
  int                idle_cycles;
  int                op_hits[8];

  handler_cycle_profiler u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .index       (index),
    .cycle       (cycle),
    .done        (done),
    .status      (status),
    .calls_done  (calls_done),
    .cycles_sum  (cycles_sum),
    .cycles_peak (cycles_peak),
    .entry_open  (entry_open),
    .instr_count (instr_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done)
        sb.check_result('{status, calls_done, cycles_sum, cycles_peak, entry_open,
                          instr_count});
      if (start && !busy) begin
        sb.note_word(operation, index, cycle);
        op_hits[operation]++;
      end
      if (done || (start && !busy)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Timeout after %0d cycles without a handshake.", idle_cycles);
          $display("handler_cycle_profiler: mismatch");
          $finish;
        end
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic drive_word(input logic [2:0] op, input logic [7:0] idx,
                            input logic [63:0] cyc, input int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start     = 1'b1;
    operation = op;
    index     = idx;
    cycle     = cyc;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [2:0]  op;
    logic [7:0]  idx;
    logic [63:0] cyc;
    logic [63:0] open_stamp;
    int          roll;
    int          gap;

    sb          = new();
    idle_cycles = 0;
    foreach (op_hits[i]) op_hits[i] = 0;
    rst       = 1'b1;
    start     = 1'b0;
    operation = OP_ENTER;
    index     = '0;
    cycle     = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    drive_word(OP_READ_SLOT, 8'd0, 64'd0, 0);
    drive_word(OP_READ_KIND, 8'd0, 64'd0, 0);
    drive_word(OP_ENTER, 8'd0, 64'd0, 0);
    drive_word(OP_EXIT, 8'd0, 64'd50, 1);
    drive_word(OP_EXIT, 8'd5, 64'd9, 0);
    drive_word(OP_ENTER, 8'd63, '1, 0);
    drive_word(OP_EXIT, 8'd63, 64'd5, 2);
    drive_word(OP_ENTER, 8'd1, 64'd1, 0);
    drive_word(OP_EXIT, 8'd1, '1, 0);
    drive_word(OP_ENTER, 8'd1, 64'd10, 0);
    drive_word(OP_EXIT, 8'd1, 64'd20, 0);
    drive_word(OP_ENTER, 8'd2, 64'd100, 0);
    drive_word(OP_ENTER, 8'd2, 64'd200, 3);
    drive_word(OP_EXIT, 8'd2, 64'd250, 0);
    drive_word(OP_ENTER, 8'd7, 64'd500, 0);
    drive_word(OP_EXIT, 8'd7, 64'd500, 0);
    drive_word(OP_COUNT, 8'd0, '1, 0);
    drive_word(OP_COUNT, 8'd255, 64'd0, 0);
    drive_word(OP_READ_KIND, 8'd255, 64'd0, 0);
    drive_word(OP_ENTER, 8'd64, 64'd77, 0);
    drive_word(OP_EXIT, 8'd255, 64'd99, 0);
    drive_word(OP_READ_SLOT, 8'd128, 64'd0, 0);
    drive_word(OP_READ_KIND + 3'd1, 8'd3, '1, 0);
    drive_word(OP_TOP, 8'd255, 64'd1, 0);
    drive_word(OP_READ_SLOT, 8'd63, 64'd0, 0);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      roll = $urandom_range(0, 99);
      idx  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7))
                                         : 8'($urandom_range(0, NUM_HANDLER_SLOTS - 1));
      cyc  = {$urandom, $urandom};
      if (roll < 30) begin
        op = OP_ENTER;
        case ($urandom_range(0, 9))
          0:       cyc = '0;
          1, 2:    cyc = {56'hFF_FFFF_FFFF_FFFF, 8'($urandom)};
          3, 4, 5: cyc = 64'($urandom_range(1, 1000));
          default: ;
        endcase
      end else if (roll < 60) begin
        op         = OP_EXIT;
        open_stamp = sb.stamp[idx];
        if (open_stamp != '0 && $urandom_range(0, 3) != 0)
          cyc = open_stamp + 64'($urandom_range(0, 5000));
      end else if (roll < 75) begin
        op  = OP_COUNT;
        idx = 8'($urandom_range(0, NUM_INSTR_KINDS - 1));
      end else if (roll < 85) begin
        op  = ($urandom_range(0, 1) == 0) ? OP_READ_SLOT : OP_READ_KIND;
        idx = 8'($urandom_range(0, 255));
      end else if (roll < 93) begin
        op  = 3'($urandom_range(0, 2));
        if (op == OP_COUNT) op = OP_READ_SLOT;
        idx = 8'($urandom_range(NUM_HANDLER_SLOTS, 255));
      end else begin
        op  = 3'($urandom_range(OP_READ_KIND + 1, OP_TOP));
        idx = 8'($urandom_range(0, 255));
      end
      gap = (n % 100 < 25) ? 0 : pick_gap();
      drive_word(op, idx, cyc, gap);
    end
    start = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Run covered %0d enter, %0d exit, %0d count, %0d read and %0d unknown words.",
             op_hits[OP_ENTER], op_hits[OP_EXIT], op_hits[OP_COUNT],
             op_hits[OP_READ_SLOT] + op_hits[OP_READ_KIND],
             op_hits[5] + op_hits[6] + op_hits[OP_TOP]);
    $display("%0d result words checked, %0d mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("handler_cycle_profiler: match");
    end else begin
      $display("handler_cycle_profiler: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/hcp_pkg.sv
design/hcp_ram.sv
design/hcp_ctrl.sv
design/hcp_datapath.sv
design/handler_cycle_profiler.sv
tb/testbench.sv
